@@ rtl/tcc_pkg.sv @@
// shared types and constants of the tcp/ipv4 capture classifier
package tcc_pkg;

  typedef enum logic [1:0] {
    OP_FRAME = 2'd0,
    OP_RULE  = 2'd1,
    OP_STAT  = 2'd2
  } opcode_t;

  localparam logic RESULT_EVENT = 1'b0;
  localparam logic RESULT_STAT  = 1'b1;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [7:0]  TLS_HANDSHAKE  = 8'h16;
  localparam logic [7:0]  TLS_MAJOR      = 8'h03;

  localparam logic [15:0] POS_ETYPE_HI   = 16'd12;
  localparam logic [15:0] POS_ETYPE_LO   = 16'd13;
  localparam logic [15:0] POS_IHL        = 16'd14;
  localparam logic [15:0] POS_PROTO      = 16'd23;
  localparam logic [15:0] POS_ADDR_FIRST = 16'd26;
  localparam logic [15:0] POS_ADDR_LAST  = 16'd33;
  localparam logic [15:0] ETH_HDR_LEN    = 16'd14;
  localparam logic [15:0] MIN_FRAME_LEN  = 16'd34;
  localparam logic [15:0] TCP_HDR_LEN    = 16'd20;
  localparam logic [15:0] TCP_DOFF_OFS   = 16'd12;
  localparam logic [15:0] TCP_HEAD_KEEP  = 16'd14;
  localparam logic [15:0] PORT_BYTES     = 16'd4;
  localparam logic [15:0] POS_MAX        = 16'hFFFF;
  localparam logic [3:0]  DOFF_MIN       = 4'd4;

  // one result word as it waits for the receiver
  typedef struct packed {
    logic        result_kind;
    logic        event_kind;
    logic [31:0] source_address;
    logic [31:0] destination_address;
    logic [15:0] source_port;
    logic [15:0] destination_port;
    logic        is_egress;
    logic [9:0]  payload_length;
    logic [63:0] stat_value;
  } result_t;

endpackage

@@ rtl/tcc_ifs.sv @@
// valid/ready channels of the tcp/ipv4 capture classifier
interface tcc_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [7:0]  frame_byte;
  logic        last_byte;
  logic        egress;
  logic [15:0] rule_port;
  logic        rule_present;
  logic        rule_enable;
  logic [1:0]  stat_index;

  modport source (output valid, opcode, frame_byte, last_byte, egress, rule_port,
                  rule_present, rule_enable, stat_index, input ready);
  modport sink   (input valid, opcode, frame_byte, last_byte, egress, rule_port,
                  rule_present, rule_enable, stat_index, output ready);
endinterface

interface tcc_rsp_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic        event_kind;
  logic [31:0] source_address;
  logic [31:0] destination_address;
  logic [15:0] source_port;
  logic [15:0] destination_port;
  logic        is_egress;
  logic [9:0]  payload_length;
  logic [63:0] stat_value;

  modport source (output valid, result_kind, event_kind, source_address,
                  destination_address, source_port, destination_port, is_egress,
                  payload_length, stat_value, input ready);
  modport sink   (input valid, result_kind, event_kind, source_address,
                  destination_address, source_port, destination_port, is_egress,
                  payload_length, stat_value, output ready);
endinterface

@@ rtl/tcp_ipv4_capture_classifier.sv @@
// top level: ethernet/ipv4/tcp header parser with port rules and traffic counters
//
// cmd carries one word per cycle while cmd.ready is high: a frame byte, a
// port rule write or a counter read (opcode). frame bytes are parsed on the
// fly; on the last byte the two tcp ports are looked up in the 64k-entry rule
// memory and the direction's counter entry is read, and in the following cycle
// the capture decision is made, the counters are written back and the event
// is queued. counter reads are queued the same way, in the cycle after acceptance.
// rsp delivers capture events and counter values through a three-word queue.
// a result passes the decision stage and then the queue before rsp offers it.
// throughput: one word per cycle while results drain; cmd.ready drops when
// the queue and the decision stage together hold three results.
// reset: a clearing pass writes every rule entry to absent, with cmd.ready
// low; counters and frame state clear at once.
// when rsp stalls, results wait in the queue and cmd.ready falls once the
// queue and the pending result would fill it.
module tcp_ipv4_capture_classifier import tcc_pkg::*; #(
  parameter int PAYLOAD_CAP  = 512,
  parameter int COUNTER_BITS = 64
) (
  input logic      clk,
  input logic      rst,
  tcc_cmd_if.sink  cmd,
  tcc_rsp_if.source rsp
);

  localparam int          CB       = COUNTER_BITS;
  localparam logic [15:0] CAP16    = 16'(PAYLOAD_CAP);
  localparam int          Q_DEPTH  = 3;
  localparam logic [1:0]  Q_LAST   = 2'(Q_DEPTH - 1);

  typedef struct packed {
    logic        is_stat;
    logic        stat_bytes;
    logic        hdr_ok;
    logic        tls;
    logic        dir;
    logic [63:0] addrs;
    logic [31:0] ports;
    logic [15:0] len;
    logic [9:0]  plen;
  } stage_t;

  // frame parse state
  logic [15:0] byte_pos;
  logic [15:0] etype;
  logic [3:0]  ihl;
  logic [7:0]  proto;
  logic [3:0]  doff;
  logic [63:0] addrs;
  logic [31:0] ports;
  logic [15:0] lead;
  logic [15:0] head_pair [4];

  // memories
  logic [1:0]      rules_mem [65536];
  logic [2*CB-1:0] cnt_mem [2];
  logic [1:0]      cnt_vld;
  logic [1:0]      rule_src_q;
  logic [1:0]      rule_dst_q;
  logic [2*CB-1:0] cnt_q;
  logic            cnt_vld_q;

  logic        clr_active;
  logic [15:0] clr_addr;

  logic            s1_valid;
  stage_t          s1;
  logic            fwd_valid;
  logic            fwd_idx;
  logic [2*CB-1:0] fwd_data;

  result_t     queue [Q_DEPTH];
  logic [1:0]  q_rd;
  logic [1:0]  q_wr;
  logic [1:0]  q_count;

  // handshake
  logic accept, frame_acc, last_acc, rule_acc, stat_acc, pop;

  assign accept    = cmd.valid && cmd.ready;
  assign frame_acc = accept && (cmd.opcode == OP_FRAME);
  assign last_acc  = frame_acc && cmd.last_byte;
  assign rule_acc  = accept && (cmd.opcode == OP_RULE);
  assign stat_acc  = accept && (cmd.opcode == OP_STAT);
  assign pop       = rsp.valid && rsp.ready;

  assign cmd.ready = !clr_active && ({1'b0, q_count} + {2'b00, s1_valid} <= 3'(Q_LAST));

  // byte parsing
  logic [7:0]  b;
  logic [15:0] etype_next;
  logic [3:0]  ihl_next, doff_next;
  logic [7:0]  proto_next;
  logic [63:0] addrs_next;
  logic [31:0] ports_next;
  logic [15:0] lead_next, t, p, off, pos_inc, plen_raw, lead_pick;
  logic        head_wr;
  logic        hdr_ok, tls_cand;

  always_comb begin
    b          = cmd.frame_byte;
    etype_next = (byte_pos == POS_ETYPE_HI || byte_pos == POS_ETYPE_LO) ?
                 {etype[7:0], b} : etype;
    ihl_next   = (byte_pos == POS_IHL) ? b[3:0] : ihl;
    proto_next = (byte_pos == POS_PROTO) ? b : proto;
    addrs_next = (byte_pos >= POS_ADDR_FIRST && byte_pos <= POS_ADDR_LAST) ?
                 {addrs[55:0], b} : addrs;
    t          = ETH_HDR_LEN + {10'b0, ihl_next, 2'b00};
    ports_next = (byte_pos >= t && byte_pos < t + PORT_BYTES) ? {ports[23:0], b} : ports;
    off        = byte_pos - t;
    head_wr    = (byte_pos >= t) && (byte_pos < t + TCP_HEAD_KEEP) && !off[1];
    doff_next  = (byte_pos == t + TCP_DOFF_OFS) ? b[7:4] : doff;
    p          = t + {10'b0, doff_next, 2'b00};
    lead_next  = lead;
    if (byte_pos > t + TCP_DOFF_OFS && doff_next >= DOFF_MIN) begin
      if (byte_pos == p) begin
        lead_next[15:8] = b;
      end
      if (byte_pos == p + 16'd1) begin
        lead_next[7:0] = b;
      end
    end
    pos_inc  = (byte_pos != POS_MAX) ? byte_pos + 16'd1 : byte_pos;
    hdr_ok   = (pos_inc >= MIN_FRAME_LEN) && (etype_next == ETHERTYPE_IPV4) &&
               (proto_next == PROTO_TCP) && (pos_inc >= t + TCP_HDR_LEN);
    // start past the end reports the cap
    if (p > pos_inc) begin
      plen_raw = CAP16;
    end else if (pos_inc - p > CAP16) begin
      plen_raw = CAP16;
    end else begin
      plen_raw = pos_inc - p;
    end
    // short data offset puts the payload start inside the kept tcp header
    lead_pick = (doff_next < DOFF_MIN) ? head_pair[doff_next[1:0]] : lead_next;
    tls_cand  = !cmd.egress && (p + 16'd2 <= pos_inc) &&
                (lead_pick == {TLS_HANDSHAKE, TLS_MAJOR});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_pos <= '0;
      etype    <= '0;
      ihl      <= '0;
      proto    <= '0;
      doff     <= '0;
      addrs    <= '0;
      ports    <= '0;
      lead     <= '0;
      for (int i = 0; i < 4; i++) begin
        head_pair[i] <= '0;
      end
    end else if (frame_acc) begin
      if (cmd.last_byte) begin
        byte_pos <= '0;
        etype    <= '0;
        ihl      <= '0;
        proto    <= '0;
        doff     <= '0;
        addrs    <= '0;
        ports    <= '0;
        lead     <= '0;
        for (int i = 0; i < 4; i++) begin
          head_pair[i] <= '0;
        end
      end else begin
        byte_pos <= pos_inc;
        etype    <= etype_next;
        ihl      <= ihl_next;
        proto    <= proto_next;
        doff     <= doff_next;
        addrs    <= addrs_next;
        ports    <= ports_next;
        lead     <= lead_next;
        if (head_wr) begin
          if (off[0]) begin
            head_pair[off[3:2]][7:0] <= b;
          end else begin
            head_pair[off[3:2]][15:8] <= b;
          end
        end
      end
    end
  end

  // rule memory: clearing pass, rule writes, two lookup reads
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else if (clr_active) begin
      clr_addr <= clr_addr + 16'd1;
      if (clr_addr == POS_MAX) begin
        clr_active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_active) begin
      rules_mem[clr_addr] <= 2'b00;
    end else if (rule_acc) begin
      rules_mem[cmd.rule_port] <= cmd.rule_present ? {1'b1, cmd.rule_enable} : 2'b00;
    end
    // ports are final well before any last byte that can pass the checks
    rule_src_q <= rules_mem[ports[31:16]];
    rule_dst_q <= rules_mem[ports[15:0]];
  end

  // counter memory, one entry per direction: {bytes, packets}
  logic            cnt_rd_idx;
  logic            cnt_we;
  logic [2*CB-1:0] cnt_cur, cnt_new;
  logic            capture;
  logic [CB-1:0]   stat_sel;
  result_t         res;
  logic            push;

  assign cnt_rd_idx = (cmd.opcode == OP_FRAME) ? cmd.egress : cmd.stat_index[0];

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[s1.dir] <= cnt_new;
    end
    cnt_q <= cnt_mem[cnt_rd_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_vld   <= '0;
      cnt_vld_q <= 1'b0;
      fwd_valid <= 1'b0;
    end else begin
      cnt_vld_q <= cnt_vld[cnt_rd_idx];
      if (cnt_we) begin
        cnt_vld[s1.dir] <= 1'b1;
      end
      fwd_valid <= cnt_we;
    end
  end

  always_ff @(posedge clk) begin
    fwd_idx  <= s1.dir;
    fwd_data <= cnt_new;
  end

  // stage 1: decision, counter update, result
  always_comb begin
    // a write at the edge of the read is not yet in the read data
    if (fwd_valid && fwd_idx == s1.dir) begin
      cnt_cur = fwd_data;
    end else if (cnt_vld_q) begin
      cnt_cur = cnt_q;
    end else begin
      cnt_cur = '0;
    end
    capture  = s1.hdr_ok && ((!rule_src_q[1] || rule_src_q[0]) ||
                             (!rule_dst_q[1] || rule_dst_q[0]));
    cnt_new  = {cnt_cur[2*CB-1:CB] + CB'(s1.len), cnt_cur[CB-1:0] + CB'(1)};
    cnt_we   = s1_valid && !s1.is_stat && capture;
    stat_sel = s1.stat_bytes ? cnt_cur[2*CB-1:CB] : cnt_cur[CB-1:0];
    res      = '0;
    if (s1.is_stat) begin
      res.result_kind = RESULT_STAT;
      res.stat_value  = 64'(stat_sel);
    end else begin
      res.result_kind         = RESULT_EVENT;
      res.event_kind          = s1.tls;
      res.source_address      = s1.addrs[63:32];
      res.destination_address = s1.addrs[31:0];
      res.source_port         = s1.ports[31:16];
      res.destination_port    = s1.ports[15:0];
      res.is_egress           = s1.dir;
      res.payload_length      = s1.plen;
    end
    push = s1_valid && (s1.is_stat || capture);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= last_acc || stat_acc;
    end
  end

  always_ff @(posedge clk) begin
    s1.is_stat    <= (cmd.opcode == OP_STAT);
    s1.stat_bytes <= cmd.stat_index[1];
    s1.hdr_ok     <= hdr_ok;
    s1.tls        <= tls_cand;
    s1.dir        <= (cmd.opcode == OP_FRAME) ? cmd.egress : cmd.stat_index[0];
    s1.addrs      <= addrs_next;
    s1.ports      <= ports_next;
    s1.len        <= pos_inc;
    s1.plen       <= plen_raw[9:0];
  end

  // result queue
  always_ff @(posedge clk) begin
    if (rst) begin
      q_rd    <= '0;
      q_wr    <= '0;
      q_count <= '0;
    end else begin
      if (push) begin
        q_wr <= (q_wr == Q_LAST) ? 2'd0 : q_wr + 2'd1;
      end
      if (pop) begin
        q_rd <= (q_rd == Q_LAST) ? 2'd0 : q_rd + 2'd1;
      end
      q_count <= q_count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue[q_wr] <= res;
    end
  end

  assign rsp.valid               = (q_count != 2'd0);
  assign rsp.result_kind         = queue[q_rd].result_kind;
  assign rsp.event_kind          = queue[q_rd].event_kind;
  assign rsp.source_address      = queue[q_rd].source_address;
  assign rsp.destination_address = queue[q_rd].destination_address;
  assign rsp.source_port         = queue[q_rd].source_port;
  assign rsp.destination_port    = queue[q_rd].destination_port;
  assign rsp.is_egress           = queue[q_rd].is_egress;
  assign rsp.payload_length      = queue[q_rd].payload_length;
  assign rsp.stat_value          = queue[q_rd].stat_value;

endmodule

@@ rtl/tcc_checker.sv @@
// port-level checks of the capture classifier and their bind
module tcc_port_checks import tcc_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        cmd_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic        rsp_result_kind,
  input logic        rsp_event_kind,
  input logic        rsp_is_egress,
  input logic [31:0] rsp_source_address,
  input logic [9:0]  rsp_payload_length,
  input logic [63:0] rsp_stat_value
);

  // the rule clearing pass keeps the command side closed right after reset
  a_clear_after_reset: assert property (@(posedge clk) $past(rst) |-> !cmd_ready)
    else $error("command accepted during rule clearing");

  // tls marking only on ingress events
  a_tls_ingress: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_result_kind == RESULT_EVENT && rsp_is_egress |-> !rsp_event_kind)
    else $error("egress event marked as tls handshake");

  // counter words carry nothing but the counter
  a_stat_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_result_kind == RESULT_STAT |->
      !rsp_event_kind && !rsp_is_egress && rsp_source_address == '0 &&
      rsp_payload_length == '0)
    else $error("counter word with event fields set");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_stat_value) &&
      $stable(rsp_result_kind))
    else $error("stalled result changed");

endmodule

bind tcp_ipv4_capture_classifier tcc_port_checks u_tcc_checker (
  .clk                (clk),
  .rst                (rst),
  .cmd_ready          (cmd.ready),
  .rsp_valid          (rsp.valid),
  .rsp_ready          (rsp.ready),
  .rsp_result_kind    (rsp.result_kind),
  .rsp_event_kind     (rsp.event_kind),
  .rsp_is_egress      (rsp.is_egress),
  .rsp_source_address (rsp.source_address),
  .rsp_payload_length (rsp.payload_length),
  .rsp_stat_value     (rsp.stat_value)
);
